@@ rtl/blind_and_relay_channel_controller_macros.svh @@
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef BLIND_AND_RELAY_CHANNEL_CONTROLLER_MACROS_SVH
`define BLIND_AND_RELAY_CHANNEL_CONTROLLER_MACROS_SVH

// same-cycle implication
`define BRC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BRC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/brc_pkg.sv @@
package brc_pkg;

	localparam int CHANNELS = 2;
	localparam int ChW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int RelW     = 2 * CHANNELS;

	localparam logic [31:0] EXTRA_RUN_MS     = 32'd500;
	localparam logic [31:0] REPORT_PERIOD_MS = 32'd1000;
	localparam logic [6:0]  PCT_FULL         = 7'd100;
	// ceil(2^37 / 100): x / 100 == (x * PCT_RECIP) >> 37 for any 32-bit x
	localparam logic [31:0] PCT_RECIP        = 32'h51EB_851F;

	localparam logic [3:0] CMD_PLUS    = 4'd0;
	localparam logic [3:0] CMD_MINUS   = 4'd1;
	localparam logic [3:0] CMD_HASH    = 4'd2;
	localparam logic [3:0] CMD_ONE     = 4'd3;
	localparam logic [3:0] CMD_ZERO    = 4'd4;
	localparam logic [3:0] CMD_PERCENT = 4'd5;
	localparam logic [3:0] CMD_BADPCT  = 4'd6;
	localparam logic [3:0] CMD_OTHER   = 4'd7;
	localparam logic [3:0] CMD_IGNORE  = 4'd8;

	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_BLIND = 2'd3;

	localparam logic [1:0] KIND_POS    = 2'd0;
	localparam logic [1:0] KIND_SWITCH = 2'd1;
	localparam logic [1:0] KIND_FINAL  = 2'd2;

	localparam logic [2:0] REG_MODE     = 3'd0;
	localparam logic [2:0] REG_TRAVEL0  = 3'd1;
	localparam logic [2:0] REG_TRAVEL1  = 3'd2;
	localparam logic [2:0] REG_HOLD0    = 3'd3;
	localparam logic [2:0] REG_HOLD1    = 3'd4;

	typedef struct packed {
		logic        mode;
		logic [31:0] now_ms;
		logic        channel;
		logic        relay_select;
		logic [3:0]  command;
		logic [9:0]  percent;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        report_channel;
		logic        report_relay;
		logic [6:0]  value;
		logic [3:0]  relay_bits;
		logic        relays_changed;
		logic [31:0] next_timeout_ms;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [3:0]  channel_mode;
		logic [23:0] travel0;
		logic [23:0] travel1;
		logic [23:0] hold0;
		logic [23:0] hold1;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [23:0] den;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quot;
	} div_rsp_t;

	function automatic logic reached(input logic [31:0] now, input logic [31:0] t);
		logic [31:0] df;
		df = now - t;
		return ~df[31];
	endfunction

	function automatic logic [31:0] tmin(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] df;
		df = b - a;
		return df[31] ? b : a;
	endfunction

endpackage

@@ rtl/brc_front.sv @@
module brc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  brc_pkg::item_t in_item,
	output logic           q_valid,
	output brc_pkg::item_t q_item,
	input  logic           q_pop
);
	import brc_pkg::*;

	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       acc, keep;

	assign full    = (cnt_q == 2'd2);
	assign acc     = push && !full;
	// commands at or above the ignore code leave no trace
	assign keep    = in_item.mode || (in_item.command < CMD_IGNORE);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (acc && keep) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc && keep) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, acc && keep} - {1'b0, q_pop};
		end
	end
endmodule

@@ rtl/brc_div.sv @@
module brc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  brc_pkg::div_req_t req,
	output brc_pkg::div_rsp_t rsp
);
	import brc_pkg::*;

	logic [31:0] num_q, quot_q;
	logic [23:0] den_q;
	logic [24:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;
	logic [24:0] sh;
	logic [25:0] diff;

	assign sh   = {rem_q[23:0], num_q[31]};
	assign diff = {1'b0, sh} - {2'b00, den_q};

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[30:0], 1'b0};
			rem_q  <= diff[25] ? sh : diff[24:0];
			quot_q <= {quot_q[30:0], ~diff[25]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

@@ rtl/brc_ofifo.sv @@
module brc_ofifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  brc_pkg::res_t wr_data,
	output logic          of_full,
	output logic          empty,
	input  logic          pop,
	output brc_pkg::res_t rd_data
);
	import brc_pkg::*;

	res_t       mem_q [8];
	logic [2:0] wp_q, rp_q;
	logic [3:0] cnt_q;
	logic       rd;

	assign of_full = (cnt_q == 4'd8);
	assign empty   = (cnt_q == 4'd0);
	assign rd      = pop && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 3'd1;
			if (rd) rp_q <= rp_q + 3'd1;
			cnt_q <= cnt_q + {3'b000, wr} - {3'b000, rd};
		end
	end
endmodule

@@ rtl/brc_back.sv @@
module brc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  brc_pkg::cfg_t     cfg,
	input  logic              q_valid,
	input  brc_pkg::item_t    q_item,
	output logic              q_pop,
	output brc_pkg::div_req_t div_req,
	input  brc_pkg::div_rsp_t div_rsp,
	output logic              wr,
	output brc_pkg::res_t     wr_data,
	input  logic              of_full
);
	import brc_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_UPD  = 4'd1;
	localparam logic [3:0] S_UPD2 = 4'd2;
	localparam logic [3:0] S_NXT  = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_PUSH = 4'd5;
	localparam logic [3:0] S_CMD  = 4'd6;
	localparam logic [3:0] S_TGT  = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;
	localparam logic [3:0] S_TGT2 = 4'd9;

	logic [3:0]  state_q, ret_q;
	item_t       it_q;
	logic [ChW-1:0] ch_q;
	logic        rep_q;
	logic [31:0] d_q, next_q, nrt_q, lut_q;
	logic [RelW-1:0] relays_q, before_q;
	logic [23:0] pos_q [CHANNELS];
	logic [31:0] chk_q [CHANNELS];
	logic [31:0] end_q [CHANNELS];
	res_t        res_q;
	logic        start_q;
	logic [31:0] num_q;
	logic [23:0] den_q;
	logic [31:0] tg_q;

	function automatic logic [1:0] mode_of(input cfg_t c, input logic [ChW-1:0] ch);
		logic [7:0] m;
		m = {4'b0000, c.channel_mode};
		if (int'(ch) >= 2) return MODE_OFF;
		return m[2*ch +: 2];
	endfunction

	function automatic logic [23:0] travel_of(input cfg_t c, input logic [ChW-1:0] ch);
		if (int'(ch) == 0) return c.travel0;
		if (int'(ch) == 1) return c.travel1;
		return '0;
	endfunction

	function automatic logic [23:0] hold_of(input cfg_t c, input logic [ChW-1:0] ch);
		if (int'(ch) == 0) return c.hold0;
		if (int'(ch) == 1) return c.hold1;
		return '0;
	endfunction

	function automatic res_t rpt(input logic [1:0] k, input logic [ChW-1:0] ch,
			input logic r, input logic [6:0] v);
		res_t x;
		x = '0;
		x.kind           = k;
		x.report_channel = ch[0];
		x.report_relay   = r;
		x.value          = v;
		return x;
	endfunction

	assign q_pop        = (state_q == S_IDLE) && q_valid;
	assign div_req.start = start_q;
	assign div_req.num   = num_q;
	assign div_req.den   = den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		logic [ChW-1:0] c;
		logic [1:0]  m;
		logic [23:0] t, h, pos;
		logic signed [33:0] p;
		logic [31:0] now, e;
		logic [63:0] prod;
		logic        b1, b2, on, off, up, tgt_go;
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			relays_q <= '0;
			before_q <= '0;
			nrt_q    <= '0;
			lut_q    <= '0;
			start_q  <= 1'b0;
			ch_q     <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				pos_q[i] <= '0;
				chk_q[i] <= '0;
				end_q[i] <= '0;
			end
		end else begin
			start_q <= 1'b0;
			now = it_q.now_ms;
			c   = ch_q;
			m   = mode_of(cfg, c);
			t   = travel_of(cfg, c);
			h   = hold_of(cfg, c);
			pos = pos_q[c];
			b1  = relays_q[2*c];
			b2  = relays_q[2*c+1];
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						it_q     <= q_item;
						before_q <= relays_q;
						ch_q     <= '0;
						d_q      <= q_item.now_ms - lut_q;
						lut_q    <= q_item.now_ms;
						if (reached(q_item.now_ms, nrt_q)) begin
							rep_q  <= 1'b1;
							nrt_q  <= q_item.now_ms + REPORT_PERIOD_MS;
							next_q <= q_item.now_ms + REPORT_PERIOD_MS;
						end else begin
							rep_q  <= 1'b0;
							next_q <= nrt_q;
						end
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (m == MODE_BLIND) begin
						if (b1 || b2) begin
							p = b1 ? ($signed({10'd0, pos}) + $signed({{2{d_q[31]}}, d_q}))
							       : ($signed({10'd0, pos}) - $signed({{2{d_q[31]}}, d_q}));
							if (p > $signed({10'd0, t})) p = $signed({10'd0, t});
							if (p < 0) p = '0;
							pos_q[c] <= p[23:0];
							if (reached(now, end_q[c])) begin
								relays_q[2*c]   <= 1'b0;
								relays_q[2*c+1] <= 1'b0;
							end else begin
								next_q <= tmin(next_q, end_q[c]);
							end
							if (rep_q || reached(now, end_q[c])) begin
								res_q <= rpt(KIND_POS, c, 1'b0, 7'd0);
								ret_q <= S_NXT;
								if (t == '0) begin
									state_q <= S_PUSH;
								end else begin
									num_q   <= 32'(p[23:0]) * 32'd100 + 32'(t[23:1]);
									den_q   <= t;
									start_q <= 1'b1;
									state_q <= S_DIV;
								end
							end else begin
								state_q <= S_NXT;
							end
						end else begin
							state_q <= S_NXT;
						end
					end else if (m != MODE_OFF) begin
						if (b1 && h != '0 && reached(now, chk_q[c])) begin
							relays_q[2*c] <= 1'b0;
							res_q   <= rpt(KIND_SWITCH, c, 1'b0, 7'd0);
							ret_q   <= S_UPD2;
							state_q <= S_PUSH;
						end else begin
							state_q <= S_UPD2;
						end
					end else begin
						state_q <= S_NXT;
					end
				end
				S_UPD2: begin
					// relay two expiry reports on its own topic
					if (b2 && t != '0 && reached(now, end_q[c])) begin
						relays_q[2*c+1] <= 1'b0;
						res_q   <= rpt(KIND_SWITCH, c, 1'b1, 7'd0);
						ret_q   <= S_NXT;
						state_q <= S_PUSH;
					end else begin
						state_q <= S_NXT;
					end
				end
				S_NXT: begin
					if (int'(ch_q) == CHANNELS - 1) begin
						ch_q    <= ChW'(it_q.channel);
						state_q <= S_CMD;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= S_UPD;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						res_q.value <= (div_rsp.quot > 32'd100) ? PCT_FULL : div_rsp.quot[6:0];
						state_q     <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (!of_full) state_q <= ret_q;
				end
				S_CMD: begin
					state_q <= S_FIN;
					if (!it_q.mode && (int'(it_q.channel) < CHANNELS)) begin
						up = (it_q.command == CMD_PLUS);
						if (m == MODE_BLIND) begin
							if (it_q.command <= CMD_ZERO) begin
								if (b1 || b2) begin
									if (up || it_q.command == CMD_MINUS ||
											(it_q.command == CMD_HASH && reached(now, chk_q[c]))) begin
										relays_q[2*c]   <= 1'b0;
										relays_q[2*c+1] <= 1'b0;
										res_q <= rpt(KIND_POS, c, 1'b0, 7'd0);
										ret_q <= S_FIN;
										if (t == '0) begin
											state_q <= S_PUSH;
										end else begin
											num_q   <= 32'(pos) * 32'd100 + 32'(t[23:1]);
											den_q   <= t;
											start_q <= 1'b1;
											state_q <= S_DIV;
										end
									end
								end else if (up || it_q.command == CMD_MINUS) begin
									chk_q[c] <= now + 32'(h);
									if (up) begin
										e = now + 32'(t) - 32'(pos) + EXTRA_RUN_MS;
										relays_q[2*c] <= 1'b1;
									end else begin
										e = now + 32'(pos) + EXTRA_RUN_MS;
										relays_q[2*c+1] <= 1'b1;
									end
									end_q[c] <= e;
									next_q   <= tmin(next_q, e);
								end
							end else if (it_q.command == CMD_PERCENT ||
									it_q.command == CMD_BADPCT) begin
								relays_q[2*c]   <= 1'b0;
								relays_q[2*c+1] <= 1'b0;
								e = end_q[c];
								tgt_go = 1'b0;
								if (it_q.command == CMD_PERCENT && it_q.percent == 10'd100) begin
									e = now + 32'(t) - 32'(pos) + EXTRA_RUN_MS;
									relays_q[2*c] <= 1'b1;
								end else if (it_q.command == CMD_PERCENT && it_q.percent == 10'd0) begin
									e = now + 32'(pos) + EXTRA_RUN_MS;
									relays_q[2*c+1] <= 1'b1;
								end else if (it_q.command == CMD_PERCENT && it_q.percent < 10'd100) begin
									// travel * percent, divided by 100 in S_TGT and used in S_TGT2
									tgt_go  = 1'b1;
									num_q   <= 32'(t) * 32'(it_q.percent[6:0]);
									state_q <= S_TGT;
								end
								// a stop-only percent still folds in the old end time
								if (!tgt_go) begin
									end_q[c] <= e;
									next_q   <= tmin(next_q, e);
								end
							end
						end else if (m != MODE_OFF) begin
							on  = (it_q.command == CMD_ONE) || (it_q.command == CMD_PLUS);
							off = (it_q.command == CMD_ZERO) || (it_q.command == CMD_MINUS);
							if (on || off) begin
								if (!it_q.relay_select) begin
									relays_q[2*c] <= on;
									if (on) begin
										chk_q[c] <= now + 32'(h);
										if (h != '0) next_q <= tmin(next_q, now + 32'(h));
									end
								end else begin
									relays_q[2*c+1] <= on;
									if (on) begin
										end_q[c] <= now + 32'(t);
										if (t != '0) next_q <= tmin(next_q, now + 32'(t));
									end
								end
								res_q   <= rpt(KIND_SWITCH, c, it_q.relay_select, {6'd0, on});
								ret_q   <= S_FIN;
								state_q <= S_PUSH;
							end
						end
					end
				end
				S_TGT: begin
					// divide by 100 through the reciprocal
					prod    = 64'(num_q) * 64'(PCT_RECIP);
					tg_q    <= 32'(prod[63:37]);
					state_q <= S_TGT2;
				end
				S_TGT2: begin
					if (tg_q > 32'(pos)) begin
						e = now + tg_q - 32'(pos);
						relays_q[2*c] <= 1'b1;
					end else begin
						e = now + 32'(pos) - tg_q;
						relays_q[2*c+1] <= 1'b1;
					end
					end_q[c] <= e;
					next_q   <= tmin(next_q, e);
					state_q  <= S_FIN;
				end
				S_FIN: begin
					if (!of_full) begin
						res_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// final beat is built combinationally from the live relay state
	logic [7:0] rel8;
	res_t       fin;
	assign rel8 = 8'(relays_q);
	always_comb begin
		fin = '0;
		fin.kind            = KIND_FINAL;
		fin.relay_bits      = rel8[3:0];
		fin.relays_changed  = (relays_q != before_q);
		fin.next_timeout_ms = next_q;
		fin.last            = 1'b1;
	end

	res_t push_data;
	assign push_data = (state_q == S_FIN) ? fin : res_q;

	logic push_fin;
	assign push_fin = (state_q == S_FIN) && !of_full;

	assign wr = ((state_q == S_PUSH) || (state_q == S_FIN)) && !of_full;
	assign wr_data = push_data;

	`include "blind_and_relay_channel_controller_macros.svh"

	`BRC_ASSERT_IMP(a_push_room, wr, !of_full, "result written into full queue")
	`BRC_ASSERT_IMP(a_div_idle, start_q, !div_rsp.busy, "divider restarted while busy")
	`BRC_ASSERT_NXT(a_fin_idle, push_fin, state_q == S_IDLE, "final beat not closing item")
	`BRC_ASSERT_IMP(a_pop_idle, q_pop, state_q == S_IDLE, "item taken mid-sequence")
endmodule

@@ rtl/blind_and_relay_channel_controller.sv @@
// Blind and relay channel controller. Items (commands or timer ticks) are
// pushed into a two-beat input queue; ignored commands are dropped there.
// A sequencer then brings every channel up to now_ms, applies the command
// and writes its result beats (position reports, switch reports, and one
// final status beat with last set) into an eight-beat result queue. An item
// is loaded in S_IDLE, each channel is updated in S_UPD (relay channels also
// in S_UPD2) and S_NXT, and the command is applied in S_CMD before S_FIN
// writes the final beat. Each switch report passes through S_PUSH, a
// percentage target through S_TGT and S_TGT2 (reciprocal multiply by 1/100),
// and each position report through S_DIV (unless travel is zero) and S_PUSH,
// since position reports share one radix-2 divider that retires one quotient
// bit per cycle.
// Configuration writes are always taken (cfg_ready is tied high) and
// must only happen while the block is idle.
module blind_and_relay_channel_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [31:0] now_ms,
	input  logic        channel,
	input  logic        relay_select,
	input  logic [3:0]  command,
	input  logic [9:0]  percent,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic        report_channel,
	output logic        report_relay,
	output logic [6:0]  value,
	output logic [3:0]  relay_bits,
	output logic        relays_changed,
	output logic [31:0] next_timeout_ms,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import brc_pkg::*;

	cfg_t     cfg_q;
	item_t    in_item, q_item;
	logic     q_valid, q_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     wr, of_full;
	res_t     wr_data, rd_data;

	assign cfg_ready = 1'b1;

	// register file; unknown indexes are accepted and dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_mode <= 4'd0;
			cfg_q.travel0      <= 24'd6500;
			cfg_q.travel1      <= 24'd6500;
			cfg_q.hold0        <= 24'd3000;
			cfg_q.hold1        <= 24'd3000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE:    cfg_q.channel_mode <= cfg_data[3:0];
				REG_TRAVEL0: cfg_q.travel0      <= cfg_data;
				REG_TRAVEL1: cfg_q.travel1      <= cfg_data;
				REG_HOLD0:   cfg_q.hold0        <= cfg_data;
				REG_HOLD1:   cfg_q.hold1        <= cfg_data;
				default:     ;
			endcase
		end
	end

	assign in_item.mode         = mode;
	assign in_item.now_ms       = now_ms;
	assign in_item.channel      = channel;
	assign in_item.relay_select = relay_select;
	assign in_item.command      = command;
	assign in_item.percent      = percent;

	brc_front u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.q_valid, .q_item, .q_pop
	);

	brc_div u_div (.clk, .arst_n, .req(div_req), .rsp(div_rsp));

	brc_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_valid, .q_item, .q_pop,
		.div_req, .div_rsp, .wr, .wr_data, .of_full
	);

	brc_ofifo u_ofifo (
		.clk, .arst_n, .wr, .wr_data, .of_full, .empty, .pop, .rd_data
	);

	assign kind            = rd_data.kind;
	assign report_channel  = rd_data.report_channel;
	assign report_relay    = rd_data.report_relay;
	assign value           = rd_data.value;
	assign relay_bits      = rd_data.relay_bits;
	assign relays_changed  = rd_data.relays_changed;
	assign next_timeout_ms = rd_data.next_timeout_ms;
	assign last            = rd_data.last;
endmodule
